FILE: rtl/plpf_pkg.sv
// Shared constants for the perpendicular foot block.
// No dependencies; used by the front, queue, back and top level.
package plpf_pkg;
   localparam int COORD_WIDTH = 32;  // default coordinate width
   localparam int QUEUE_DEPTH = 4;   // words between front and back
endpackage

FILE: rtl/plpf_front.sv
// Front part: accepts a query word, forms D = B-A, products and the dot sums.
// Depends on plpf_pkg for the default width.
module plpf_front #(
   parameter int W = plpf_pkg::COORD_WIDTH,
   localparam int FW = 3*W + 3*(W+1) + (2*W+2) + (2*W+3)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [W-1:0] req_point_x,
   input  logic signed [W-1:0] req_point_y,
   input  logic signed [W-1:0] req_point_z,
   input  logic signed [W-1:0] req_line_a_x,
   input  logic signed [W-1:0] req_line_a_y,
   input  logic signed [W-1:0] req_line_a_z,
   input  logic signed [W-1:0] req_line_b_x,
   input  logic signed [W-1:0] req_line_b_y,
   input  logic signed [W-1:0] req_line_b_z,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [FW-1:0]       out_data
);
   logic signed [W-1:0] p [3];
   logic signed [W-1:0] a [3];
   logic signed [W-1:0] b [3];
   logic en;

   logic v1_ff, v2_ff, v3_ff;
   logic signed [W-1:0]   a1_ff [3], a2_ff [3], a3_ff [3];
   logic signed [W:0]     d1_ff [3], d2_ff [3], d3_ff [3];
   logic signed [W:0]     e1_ff [3];
   logic signed [2*W+1:0] sq_ff [3], pr_ff [3];
   logic [2*W+1:0]        dd_ff;
   logic signed [2*W+2:0] n_ff;

   assign p = '{req_point_x, req_point_y, req_point_z};
   assign a = '{req_line_a_x, req_line_a_y, req_line_a_z};
   assign b = '{req_line_b_x, req_line_b_y, req_line_b_z};

   assign en        = !v3_ff || out_ready;
   assign req_ready = en;
   assign out_valid = v3_ff;
   assign out_data  = {a3_ff[0], a3_ff[1], a3_ff[2], d3_ff[0], d3_ff[1], d3_ff[2],
                       dd_ff, n_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            a1_ff[i] <= a[i];
            d1_ff[i] <= (W+1)'(b[i]) - (W+1)'(a[i]);
            e1_ff[i] <= (W+1)'(p[i]) - (W+1)'(a[i]);
            a2_ff[i] <= a1_ff[i];
            d2_ff[i] <= d1_ff[i];
            sq_ff[i] <= d1_ff[i] * d1_ff[i];
            pr_ff[i] <= e1_ff[i] * d1_ff[i];
            a3_ff[i] <= a2_ff[i];
            d3_ff[i] <= d2_ff[i];
         end
         // squares are nonnegative, so the unsigned view is exact
         dd_ff <= (2*W+2)'(unsigned'(sq_ff[0])) + (2*W+2)'(unsigned'(sq_ff[1]))
                + (2*W+2)'(unsigned'(sq_ff[2]));
         n_ff  <= (2*W+3)'(pr_ff[0]) + (2*W+3)'(pr_ff[1]) + (2*W+3)'(pr_ff[2]);
      end
   end
endmodule

FILE: rtl/plpf_queue.sv
// Short word queue that decouples the front and back parts.
// Depends on plpf_pkg for the default depth.
module plpf_queue #(
   parameter int DW    = 8,
   parameter int DEPTH = plpf_pkg::QUEUE_DEPTH,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [DW-1:0] in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [DW-1:0] out_data
);
   logic [DW-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   cnt_ff;
   logic push, pop;

   assign in_ready  = cnt_ff != (AW+1)'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
      if (push) mem_ff[wr_ff] <= in_data;
   end
endmodule

FILE: rtl/plpf_back.sv
// Back part: N*D in split products, a pipelined restoring divider per axis,
// truncation toward zero and saturation. Depends on plpf_pkg.
module plpf_back #(
   parameter int W = plpf_pkg::COORD_WIDTH,
   localparam int FW = 3*W + 3*(W+1) + (2*W+2) + (2*W+3)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [FW-1:0]       in_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [W-1:0] rsp_foot_x,
   output logic signed [W-1:0] rsp_foot_y,
   output logic signed [W-1:0] rsp_foot_z,
   output logic                rsp_clipped
);
   localparam int NW  = 2*W+3;   // N width
   localparam int LOW = W+2;     // low slice of N
   localparam int HW  = NW-LOW;  // high slice of N
   localparam int MW  = 3*W+4;   // N*D width
   localparam int RW  = 2*W+3;   // partial remainder width
   localparam int QW  = W+3;     // quotient bits
   localparam int TW  = QW+2;    // foot before saturation

   logic en;
   logic signed [W-1:0]   ia [3];
   logic signed [W:0]     id [3];
   logic [2*W+1:0]        idd;
   logic signed [NW-1:0]  in_n;

   assign {ia[0], ia[1], ia[2], id[0], id[1], id[2], idd, in_n} = in_data;

   // stage 1: partial products, stage 2: N*D
   logic v1_ff, v2_ff;
   logic signed [W-1:0]   a1_ff [3], a2_ff [3];
   logic [2*W+1:0]        dd1_ff, dd2_ff;
   logic signed [2*W+3:0] plo_ff [3];
   logic signed [2*W+1:0] phi_ff [3];
   logic signed [MW-1:0]  nd_ff [3];

   // divider stages 0..QW
   logic                 dv_ff  [QW+1];
   logic                 dz_ff  [QW+1];
   logic [2*W+1:0]       ddd_ff [QW+1];
   logic signed [W-1:0]  da_ff  [QW+1][3];
   logic                 dn_ff  [QW+1][3];
   logic [RW-1:0]        rem_ff [QW+1][3];
   logic [QW-1:0]        nlo_ff [QW+1][3];
   logic [QW-1:0]        q_ff   [QW+1][3];

   logic [MW-1:0] mag [3];
   logic [RW-1:0] cand   [QW][3];
   logic          ge     [QW][3];

   logic vo_ff;
   logic signed [W-1:0] foot_ff [3];
   logic clip_ff;
   logic signed [W-1:0] foot_in [3];
   logic clip_in;

   assign en       = !vo_ff || rsp_ready;
   assign in_ready = en;

   always_comb begin
      for (int i = 0; i < 3; i++)
         mag[i] = nd_ff[i][MW-1] ? MW'(-nd_ff[i]) : MW'(nd_ff[i]);
      for (int k = 0; k < QW; k++)
         for (int i = 0; i < 3; i++) begin
            cand[k][i] = {rem_ff[k][i][RW-2:0], nlo_ff[k][i][QW-1]};
            ge[k][i]   = cand[k][i] >= RW'(ddd_ff[k]);
         end
   end

   // truncate toward zero, then saturate
   always_comb begin
      logic signed [TW-1:0] t;
      logic signed [TW-1:0] qs;
      logic signed [TW-1:0] hi_lim;
      logic signed [TW-1:0] lo_lim;
      logic frac;
      hi_lim  = TW'($signed({1'b0, {(W-1){1'b1}}}));
      lo_lim  = -hi_lim - TW'(1);
      clip_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         qs   = $signed({2'b00, q_ff[QW][i]});
         frac = rem_ff[QW][i] != '0;
         t    = dn_ff[QW][i] ? TW'(da_ff[QW][i]) - qs : TW'(da_ff[QW][i]) + qs;
         if (!dn_ff[QW][i] && frac && t < 0) t = t + TW'(1);
         if (dn_ff[QW][i] && frac && t > 0)  t = t - TW'(1);
         if (dz_ff[QW]) begin
            foot_in[i] = da_ff[QW][i];
         end else if (t > hi_lim) begin
            foot_in[i] = hi_lim[W-1:0];
            clip_in    = 1'b1;
         end else if (t < lo_lim) begin
            foot_in[i] = lo_lim[W-1:0];
            clip_in    = 1'b1;
         end else begin
            foot_in[i] = t[W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         for (int k = 0; k <= QW; k++) dv_ff[k] <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         dv_ff[0] <= v2_ff;
         for (int k = 1; k <= QW; k++) dv_ff[k] <= dv_ff[k-1];
         vo_ff <= dv_ff[QW];
      end
      if (en) begin
         dd1_ff <= idd;
         dd2_ff <= dd1_ff;
         for (int i = 0; i < 3; i++) begin
            a1_ff[i]  <= ia[i];
            plo_ff[i] <= $signed({1'b0, in_n[LOW-1:0]}) * id[i];
            phi_ff[i] <= $signed(in_n[NW-1:LOW]) * id[i];
            a2_ff[i]  <= a1_ff[i];
            nd_ff[i]  <= (MW'(phi_ff[i]) <<< LOW) + MW'(plo_ff[i]);
         end
         // divider load: upper numerator bits start the remainder
         dz_ff[0]  <= dd2_ff == '0;
         ddd_ff[0] <= dd2_ff;
         for (int i = 0; i < 3; i++) begin
            da_ff[0][i]  <= a2_ff[i];
            dn_ff[0][i]  <= nd_ff[i][MW-1];
            rem_ff[0][i] <= RW'(mag[i][MW-1:QW]);
            nlo_ff[0][i] <= mag[i][QW-1:0];
            q_ff[0][i]   <= '0;
         end
         for (int k = 0; k < QW; k++) begin
            dz_ff[k+1]  <= dz_ff[k];
            ddd_ff[k+1] <= ddd_ff[k];
            for (int i = 0; i < 3; i++) begin
               da_ff[k+1][i]  <= da_ff[k][i];
               dn_ff[k+1][i]  <= dn_ff[k][i];
               rem_ff[k+1][i] <= ge[k][i] ? cand[k][i] - RW'(ddd_ff[k]) : cand[k][i];
               nlo_ff[k+1][i] <= nlo_ff[k][i] << 1;
               q_ff[k+1][i]   <= {q_ff[k][i][QW-2:0], ge[k][i]};
            end
         end
         for (int i = 0; i < 3; i++) foot_ff[i] <= foot_in[i];
         clip_ff <= clip_in;
      end
   end

   assign rsp_valid   = vo_ff;
   assign rsp_foot_x  = foot_ff[0];
   assign rsp_foot_y  = foot_ff[1];
   assign rsp_foot_z  = foot_ff[2];
   assign rsp_clipped = clip_ff;
endmodule

FILE: rtl/point_line_perpendicular_foot.sv
// Top level of the point-to-line perpendicular foot block.
// Depends on plpf_pkg, plpf_front, plpf_queue and plpf_back.
//
// Returns the foot F of the perpendicular from point P onto the line through A and B,
// F = A + ((P-A).D / D.D) * D with D = B-A, exact, each axis truncated toward zero
// and saturated to the signed coordinate range; rsp_clipped flags any saturation.
// When A equals B the foot is A. One word is accepted per cycle and one result word
// leaves per cycle unless rsp_ready is low with a result waiting. The path runs
// through three front stages (difference, products, dot sums), the queue, two stages
// for the split N*D product, a divider load stage, W + 3 restoring divider stages
// (one quotient bit each) and the output register. The front keeps accepting while
// the back is stalled until the four-word queue fills.
module point_line_perpendicular_foot #(
   parameter int COORD_WIDTH = plpf_pkg::COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,
   input  logic signed [COORD_WIDTH-1:0] req_line_a_x,
   input  logic signed [COORD_WIDTH-1:0] req_line_a_y,
   input  logic signed [COORD_WIDTH-1:0] req_line_a_z,
   input  logic signed [COORD_WIDTH-1:0] req_line_b_x,
   input  logic signed [COORD_WIDTH-1:0] req_line_b_y,
   input  logic signed [COORD_WIDTH-1:0] req_line_b_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_foot_x,
   output logic signed [COORD_WIDTH-1:0] rsp_foot_y,
   output logic signed [COORD_WIDTH-1:0] rsp_foot_z,
   output logic                          rsp_clipped
);
   localparam int W  = COORD_WIDTH;
   // queue word: A, D, D.D and N
   localparam int FW = 3*W + 3*(W+1) + (2*W+2) + (2*W+3);

   logic          f_valid, f_ready, b_valid, b_ready;
   logic [FW-1:0] f_data, b_data;

   plpf_front #(.W(W)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_point_z  (req_point_z),
      .req_line_a_x (req_line_a_x),
      .req_line_a_y (req_line_a_y),
      .req_line_a_z (req_line_a_z),
      .req_line_b_x (req_line_b_x),
      .req_line_b_y (req_line_b_y),
      .req_line_b_z (req_line_b_z),
      .out_valid    (f_valid),
      .out_ready    (f_ready),
      .out_data     (f_data)
   );

   plpf_queue #(.DW(FW), .DEPTH(plpf_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (b_data)
   );

   plpf_back #(.W(W)) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (b_valid),
      .in_ready    (b_ready),
      .in_data     (b_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_foot_x  (rsp_foot_x),
      .rsp_foot_y  (rsp_foot_y),
      .rsp_foot_z  (rsp_foot_z),
      .rsp_clipped (rsp_clipped)
   );
endmodule
